### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication or plain property that must hold at every clock edge.
`define URPEF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge.
`define URPEF_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define URPEF_ASSERT(lbl, prop, msg)
`define URPEF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hdl/urpef_pkg.sv
// ----------------------------------------------------------------------------
// urpef_pkg
// Types and constants shared by the reply parser and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package urpef_pkg;

	// Default depth of the expected echo ring.
	localparam int unsigned ECHO_DEPTH_DEF = 16;

	// Field widths.
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned EVT_W   = 3;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDATA_W = 16;
	localparam int unsigned WIN_W   = 16;
	localparam int unsigned AGE_W   = 17;
	localparam int unsigned PIDX_W  = 3;

	// Saturation value of the echo age counter.
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// Reply header codes.
	localparam logic [BYTE_W-1:0] HDR_COUNT    = 8'hCB;
	localparam logic [BYTE_W-1:0] HDR_POSITION = 8'hF5;
	localparam logic [BYTE_W-1:0] HDR_DURATION = 8'hF7;

	// Payload lengths of the headers.
	localparam logic [PIDX_W-1:0] LEN_COUNT = 3'd1;
	localparam logic [PIDX_W-1:0] LEN_WORD  = 3'd4;

	// Reset values.
	localparam logic                FILTER_RST  = 1'b1;
	localparam logic [BYTE_W-1:0]   HIGHEST_RST = 8'd199;
	localparam logic [BYTE_W-1:0]   END_RST     = 8'd255;
	localparam logic [WIN_W-1:0]    WINDOW_RST  = 16'd100;
	localparam logic [BYTE_W-1:0]   LAST_RST    = 8'd255;

	// Input item kinds; the fourth code is unused and ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_RX   = 2'd0,
		KIND_TX   = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	// Reported events.
	typedef enum logic [EVT_W-1:0] {
		EVT_FILE     = 3'd0,
		EVT_EOF      = 3'd1,
		EVT_COUNT    = 3'd2,
		EVT_POSITION = 3'd3,
		EVT_DURATION = 3'd4
	} evt_t;

	// Reply parser mode.
	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_COUNT    = 2'd1,
		MODE_POSITION = 2'd2,
		MODE_DURATION = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_FILTER_ON = 2'd0,
		CFG_HIGHEST   = 2'd1,
		CFG_END_CODE  = 2'd2,
		CFG_WINDOW    = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

### hdl/urpef_item_if.sv
// ----------------------------------------------------------------------------
// urpef_item_if
// Input channel: received byte, transmitted byte or time tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface urpef_item_if;
	logic                             valid;
	logic                             ready;
	logic [urpef_pkg::KIND_W-1:0]     kind;
	logic [urpef_pkg::BYTE_W-1:0]     data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

### hdl/urpef_result_if.sv
// ----------------------------------------------------------------------------
// urpef_result_if
// Result channel: reported event and its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface urpef_result_if;
	logic                             valid;
	logic                             ready;
	logic [urpef_pkg::EVT_W-1:0]      event_res;
	logic [urpef_pkg::VALUE_W-1:0]    value;

	modport source (output valid, output event_res, output value, input ready);
	modport sink   (input valid, input event_res, input value, output ready);
endinterface

`default_nettype wire

### hdl/urpef_cfg_if.sv
// ----------------------------------------------------------------------------
// urpef_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface urpef_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [urpef_pkg::CIDX_W-1:0]     index;
	logic [urpef_pkg::CDATA_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/urpef_ram.sv
// ----------------------------------------------------------------------------
// urpef_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module urpef_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/uart_reply_parser_echo_filter.sv
// ----------------------------------------------------------------------------
// uart_reply_parser_echo_filter: items pass the input stage, then the result register.
// Throughput one item per cycle unless results stall; ring RAM read is prefetched.
// Asynchronous active-low reset; the ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uart_reply_parser_echo_filter #(
	parameter int unsigned ECHO_DEPTH = urpef_pkg::ECHO_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	urpef_item_if.sink         item,
	urpef_result_if.source     result,
	urpef_cfg_if.sink          cfg
);

	localparam int unsigned HEAD_W = $clog2(ECHO_DEPTH);
	localparam int unsigned CNT_W  = $clog2(ECHO_DEPTH + 1);
	localparam int unsigned SUM_W  = HEAD_W + 1;

	localparam int unsigned BW = urpef_pkg::BYTE_W;

	// Configuration registers.
	logic                         filt_q;
	logic [BW-1:0]                hi_q;
	logic [BW-1:0]                end_q;
	logic [urpef_pkg::WIN_W-1:0]  win_q;

	// Input stage.
	logic                         valid_s1;
	logic [urpef_pkg::KIND_W-1:0] kind_s1;
	logic [BW-1:0]                byte_s1;

	// Parser and ring state.
	urpef_pkg::mode_t             mode_q, mode_d;
	logic [urpef_pkg::PIDX_W-1:0] pidx_q, pidx_d;
	logic [urpef_pkg::PIDX_W-1:0] plen_q, plen_d;
	logic [BW-1:0]                pb_q [4];
	logic [BW-1:0]                pb_d [4];
	logic [BW-1:0]                last_q, last_d;
	logic [HEAD_W-1:0]            head_q, head_d;
	logic [CNT_W-1:0]             cnt_q, cnt_d;
	logic [urpef_pkg::AGE_W-1:0]  age_q, age_d;

	// Result register.
	logic                         out_valid_q;
	urpef_pkg::evt_t              out_event_q;
	logic [urpef_pkg::VALUE_W-1:0] out_value_q;

	// Combinational result of the current item.
	logic                         res_emit;
	urpef_pkg::evt_t              res_event;
	logic [urpef_pkg::VALUE_W-1:0] res_value;
	logic                         popped;

	// Ring RAM access and same-address bypass.
	logic                         ram_we;
	logic [HEAD_W-1:0]            ram_waddr;
	logic [BW-1:0]                ram_rdata;
	logic                         byp_q;
	logic [BW-1:0]                byp_data_q;
	logic [BW-1:0]                head_data;

	// Ring pointer helpers.
	logic                         ring_full;
	logic [HEAD_W-1:0]            head_inc;
	logic [HEAD_W-1:0]            head_a;
	logic [CNT_W-1:0]             cnt_a;
	logic [SUM_W-1:0]             tail_sum;
	logic [HEAD_W-1:0]            tail;

	logic                         s1_fire;
	logic                         in_fire;

	// Handshake: the input stage advances whenever the result register is free or drains.
	assign s1_fire    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || s1_fire;
	assign in_fire    = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid     = out_valid_q;
	assign result.event_res = out_event_q;
	assign result.value     = out_value_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= urpef_pkg::FILTER_RST;
			hi_q   <= urpef_pkg::HIGHEST_RST;
			end_q  <= urpef_pkg::END_RST;
			win_q  <= urpef_pkg::WINDOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				urpef_pkg::CFG_FILTER_ON: filt_q <= cfg.wdata[0];
				urpef_pkg::CFG_HIGHEST:   hi_q   <= cfg.wdata[BW-1:0];
				urpef_pkg::CFG_END_CODE:  end_q  <= cfg.wdata[BW-1:0];
				urpef_pkg::CFG_WINDOW:    win_q  <= cfg.wdata;
				default:                  filt_q <= filt_q;
			endcase
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.data_byte;
		end
	end

	// Ring pointer arithmetic: drop the oldest entry when full, then find the tail.
	assign ring_full = (cnt_q == CNT_W'(ECHO_DEPTH));
	assign head_inc  = (head_q == HEAD_W'(ECHO_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_a    = ring_full ? head_inc : head_q;
	assign cnt_a     = ring_full ? CNT_W'(ECHO_DEPTH - 1) : cnt_q;
	assign tail_sum  = SUM_W'(head_a) + SUM_W'(cnt_a);
	assign tail      = (tail_sum >= SUM_W'(ECHO_DEPTH)) ?
		HEAD_W'(tail_sum - SUM_W'(ECHO_DEPTH)) : HEAD_W'(tail_sum);
	assign ram_waddr = tail;

	// Oldest expected echo, forwarded when it was written in the previous cycle.
	assign head_data = byp_q ? byp_data_q : ram_rdata;

	// Next state and result of the item in the input stage.
	always_comb begin
		mode_d    = mode_q;
		pidx_d    = pidx_q;
		plen_d    = plen_q;
		pb_d      = pb_q;
		last_d    = last_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		age_d     = age_q;
		res_emit  = 1'b0;
		res_event = urpef_pkg::EVT_FILE;
		res_value = '0;
		ram_we    = 1'b0;
		popped    = 1'b0;
		if (s1_fire) begin
			unique case (kind_s1)
				urpef_pkg::KIND_RX: begin
					if (mode_q != urpef_pkg::MODE_IDLE) begin
						// Collect a payload byte and report once the payload is complete.
						pb_d[pidx_q[1:0]] = byte_s1;
						pidx_d = pidx_q + 1'b1;
						if (!(pidx_d < plen_q)) begin
							res_emit = 1'b1;
							mode_d   = urpef_pkg::MODE_IDLE;
							if (mode_q == urpef_pkg::MODE_COUNT) begin
								res_event = urpef_pkg::EVT_COUNT;
								res_value = {24'd0, pb_d[0]};
							end else begin
								res_event = (mode_q == urpef_pkg::MODE_POSITION) ?
									urpef_pkg::EVT_POSITION : urpef_pkg::EVT_DURATION;
								res_value = {pb_d[0], pb_d[1], pb_d[2], pb_d[3]};
							end
						end
					end else begin
						// Drop stale echoes, or swallow a byte that matches the oldest one.
						if (cnt_q != '0) begin
							if (age_q > {1'b0, win_q}) begin
								head_d = '0;
								cnt_d  = '0;
							end else if (byte_s1 == head_data) begin
								head_d = head_inc;
								cnt_d  = cnt_q - 1'b1;
								popped = 1'b1;
							end
						end
						// Classify a byte that is not an echo.
						if (!popped) begin
							priority if (byte_s1 <= hi_q) begin
								if (byte_s1 != last_q) begin
									last_d    = byte_s1;
									res_emit  = 1'b1;
									res_event = urpef_pkg::EVT_FILE;
									res_value = {24'd0, byte_s1};
								end
							end else if (byte_s1 == end_q) begin
								res_emit  = 1'b1;
								res_event = urpef_pkg::EVT_EOF;
							end else if (byte_s1 == urpef_pkg::HDR_COUNT) begin
								mode_d = urpef_pkg::MODE_COUNT;
								pidx_d = '0;
								plen_d = urpef_pkg::LEN_COUNT;
							end else if (byte_s1 == urpef_pkg::HDR_POSITION) begin
								mode_d = urpef_pkg::MODE_POSITION;
								pidx_d = '0;
								plen_d = urpef_pkg::LEN_WORD;
							end else if (byte_s1 == urpef_pkg::HDR_DURATION) begin
								mode_d = urpef_pkg::MODE_DURATION;
								pidx_d = '0;
								plen_d = urpef_pkg::LEN_WORD;
							end
						end
					end
				end
				urpef_pkg::KIND_TX: begin
					// With filtering on, queue the transmitted byte as an expected echo.
					if (filt_q) begin
						head_d = head_a;
						cnt_d  = cnt_a + 1'b1;
						ram_we = 1'b1;
						age_d  = '0;
					end
				end
				urpef_pkg::KIND_TICK: begin
					if (age_q != urpef_pkg::AGE_MAX) begin
						age_d = age_q + 1'b1;
					end
				end
				default: begin
					age_d = age_q;
				end
			endcase
		end
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= urpef_pkg::MODE_IDLE;
			pidx_q <= '0;
			plen_q <= '0;
			last_q <= urpef_pkg::LAST_RST;
			head_q <= '0;
			cnt_q  <= '0;
			age_q  <= '0;
			byp_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			pidx_q <= pidx_d;
			plen_q <= plen_d;
			last_q <= last_d;
			head_q <= head_d;
			cnt_q  <= cnt_d;
			age_q  <= age_d;
			byp_q  <= ram_we && (ram_waddr == head_d);
		end
	end

	// Payload bytes and bypass data.
	always_ff @(posedge clk) begin
		pb_q       <= pb_d;
		byp_data_q <= byte_s1;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= res_emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_emit) begin
			out_event_q <= res_event;
			out_value_q <= res_value;
		end
	end

	// Expected echo ring; read address follows the next head so the oldest
	// entry is ready for the following item.
	urpef_ram #(
		.WIDTH (BW),
		.DEPTH (ECHO_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (byte_s1),
		.raddr (head_d),
		.rdata (ram_rdata)
	);

	// Assertions.
	`URPEF_ASSERT_NEVER(a_cnt_bound, cnt_q > CNT_W'(ECHO_DEPTH), "echo count above ring depth")
	`URPEF_ASSERT_NEVER(a_head_bound, head_q > HEAD_W'(ECHO_DEPTH - 1), "echo head outside ring")
	`URPEF_ASSERT(a_plen_valid, (mode_q != urpef_pkg::MODE_IDLE) |->
		(plen_q == urpef_pkg::LEN_COUNT || plen_q == urpef_pkg::LEN_WORD),
		"payload length does not match header")
	`URPEF_ASSERT(a_rx_only_result,
		(s1_fire && kind_s1 != urpef_pkg::KIND_RX) |-> !res_emit,
		"result from an item that is not a received byte")

endmodule

`default_nettype wire
